[src/bmcs_pkg.sv]
// Package for the checkerboard swap block: field widths, codes, item and
// result types shared by the interfaces, the evaluator and the top level.
`default_nettype none
package bmcs_pkg;

   localparam int DEF_MAX_ROWS = 64;
   localparam int DEF_MAX_COLS = 64;

   localparam int MODE_W  = 2;
   localparam int IDX_W   = 6;
   localparam int LIM_W   = 7;
   localparam int CNT_W   = 31;
   localparam int CSR_A_W = 2;
   localparam int CSR_D_W = 31;

   typedef enum logic [MODE_W-1:0] {
      MODE_LOAD = 2'd0,
      MODE_SWAP = 2'd1,
      MODE_READ = 2'd2,
      MODE_NOP  = 2'd3
   } bmcs_mode_type;

   typedef enum logic [CSR_A_W-1:0] {
      CSR_NUM_ROWS = 2'd0,
      CSR_NUM_COLS = 2'd1,
      CSR_TARGET   = 2'd2
   } bmcs_csr_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_WRB
   } bmcs_state_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [IDX_W-1:0]  row_a;
      logic [IDX_W-1:0]  row_b;
      logic [IDX_W-1:0]  col_a;
      logic [IDX_W-1:0]  col_b;
      logic              load_bit;
   } bmcs_req_type;

   typedef struct packed {
      logic             read_bit;
      logic             swapped;
      logic [CNT_W-1:0] swaps_done;
      logic             done_res;
      logic             index_error;
   } bmcs_rsp_type;

   typedef struct packed {
      logic index_error;
      logic hit;
      logic read_bit;
      logic wr_a;
   } bmcs_eval_type;

endpackage
`default_nettype wire

[src/bmcs_ifs.sv]
// Channel interfaces of the checkerboard swap block: request, response and
// register write. Depends on bmcs_pkg for field widths.
`default_nettype none
interface bmcs_req_if;
   import bmcs_pkg::*;
   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [IDX_W-1:0]  row_a;
   logic [IDX_W-1:0]  row_b;
   logic [IDX_W-1:0]  col_a;
   logic [IDX_W-1:0]  col_b;
   logic              load_bit;
   modport source (output valid, mode, row_a, row_b, col_a, col_b, load_bit, input ready);
   modport sink (input valid, mode, row_a, row_b, col_a, col_b, load_bit, output ready);
endinterface

interface bmcs_rsp_if;
   import bmcs_pkg::*;
   logic             valid;
   logic             ready;
   logic             read_bit;
   logic             swapped;
   logic [CNT_W-1:0] swaps_done;
   logic             done_res;
   logic             index_error;
   modport source (output valid, read_bit, swapped, swaps_done, done_res, index_error,
                   input ready);
   modport sink (input valid, read_bit, swapped, swaps_done, done_res, index_error,
                 output ready);
endinterface

interface bmcs_csr_if;
   import bmcs_pkg::*;
   logic               valid;
   logic               ready;
   logic [CSR_A_W-1:0] index;
   logic [CSR_D_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[src/bmcs_ram.sv]
// Generic single-write, dual-read RAM with registered read data.
// Depends on bmcs_pkg for default sizes.
`default_nettype none
module bmcs_ram #(
   parameter int WIDTH = bmcs_pkg::DEF_MAX_COLS,
   parameter int DEPTH = bmcs_pkg::DEF_MAX_ROWS,
   localparam int AW   = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr_a,
   input  wire logic [AW-1:0]    raddr_b,
   output logic      [WIDTH-1:0] rdata_a,
   output logic      [WIDTH-1:0] rdata_b
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_a_ff;
   logic [WIDTH-1:0] rdata_b_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_a_ff <= mem_ff[raddr_a];
      rdata_b_ff <= mem_ff[raddr_b];
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;
endmodule
`default_nettype wire

[src/bmcs_eval.sv]
// Evaluates one word against the two fetched row words: range check, cell
// read, load merge and checkerboard test, with the two cells of each row inverted. Uses bmcs_pkg.
`default_nettype none
module bmcs_eval #(
   parameter int MAX_ROWS = bmcs_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = bmcs_pkg::DEF_MAX_COLS
) (
   input  wire bmcs_pkg::bmcs_req_type          item,
   input  wire logic [bmcs_pkg::LIM_W-1:0]      num_rows,
   input  wire logic [bmcs_pkg::LIM_W-1:0]      num_cols,
   input  wire logic [bmcs_pkg::CNT_W-1:0]      swap_cnt,
   input  wire logic [bmcs_pkg::CNT_W-1:0]      target,
   input  wire logic [MAX_COLS-1:0]             row_a_word,
   input  wire logic [MAX_COLS-1:0]             row_b_word,
   output bmcs_pkg::bmcs_eval_type              flags,
   output logic      [MAX_COLS-1:0]             new_a,
   output logic      [MAX_COLS-1:0]             new_b
);
   import bmcs_pkg::*;

   localparam int COL_W = $clog2(MAX_COLS);

   logic             ra_ok, rb_ok, ca_ok, cb_ok;
   logic [COL_W-1:0] ca_idx, cb_idx;
   logic [MAX_COLS-1:0] bit_ca, bit_cb, mask;
   logic             a, b, c, d, board;

   always_comb begin
      ra_ok = ({1'b0, item.row_a} < num_rows) && (32'(item.row_a) < MAX_ROWS);
      rb_ok = ({1'b0, item.row_b} < num_rows) && (32'(item.row_b) < MAX_ROWS);
      ca_ok = ({1'b0, item.col_a} < num_cols) && (32'(item.col_a) < MAX_COLS);
      cb_ok = ({1'b0, item.col_b} < num_cols) && (32'(item.col_b) < MAX_COLS);
      ca_idx = COL_W'(item.col_a);
      cb_idx = COL_W'(item.col_b);
      bit_ca = {{(MAX_COLS-1){1'b0}}, 1'b1} << ca_idx;
      bit_cb = {{(MAX_COLS-1){1'b0}}, 1'b1} << cb_idx;
      mask   = bit_ca | bit_cb;
      a = row_a_word[ca_idx];
      b = row_a_word[cb_idx];
      c = row_b_word[ca_idx];
      d = row_b_word[cb_idx];
      board = (a == d) && (b == c) && (a != b);

      flags = '0;
      new_a = row_a_word ^ mask;
      new_b = row_b_word ^ mask;
      case (item.mode)
         MODE_LOAD: begin
            flags.index_error = !(ra_ok && ca_ok);
            flags.wr_a        = ra_ok && ca_ok;
            new_a = item.load_bit ? (row_a_word | bit_ca) : (row_a_word & ~bit_ca);
         end
         MODE_READ: begin
            flags.index_error = !(ra_ok && ca_ok);
            flags.read_bit    = ra_ok && ca_ok && a;
         end
         MODE_SWAP: begin
            flags.index_error = !(ra_ok && rb_ok && ca_ok && cb_ok);
            flags.hit = ra_ok && rb_ok && ca_ok && cb_ok && (swap_cnt < target)
                        && (item.row_a != item.row_b) && (item.col_a != item.col_b)
                        && board;
            flags.wr_a = flags.hit;
         end
         default: begin
            flags = '0;
         end
      endcase
   end
endmodule
`default_nettype wire

[src/binary_matrix_checkerboard_swap.sv]
// Channel  | Dir | Payload                                              | Handshake
// req_ch   | in  | mode, row_a, row_b, col_a, col_b, load_bit           | valid/ready
// rsp_ch   | out | read_bit, swapped, swaps_done, done_res, index_error | valid/ready
// csr_ch   | in  | index (0 rows, 1 cols, 2 target), data               | valid/ready
//
// Load, read, no-op and failed swap words pass the accept and evaluate steps; a
// successful swap adds a write-back step for the second row, as the row RAM has a
// single write port. After reset a clearing pass zeroes every row of the row RAM;
// no word is taken meanwhile, register writes are. A waiting response stalls only the
// evaluate step; the next request word is taken while a response is held.
// Top level; depends on bmcs_pkg, bmcs_ifs, bmcs_ram and bmcs_eval.
`default_nettype none
module binary_matrix_checkerboard_swap #(
   parameter int MAX_ROWS = bmcs_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = bmcs_pkg::DEF_MAX_COLS
) (
   input wire logic    clock,
   input wire logic    reset,
   bmcs_req_if.sink    req_ch,
   bmcs_rsp_if.source  rsp_ch,
   bmcs_csr_if.sink    csr_ch
);
   import bmcs_pkg::*;

   localparam int ROW_W = $clog2(MAX_ROWS);

   bmcs_state_type      state_ff, state_in;
   logic [ROW_W-1:0]    clr_ptr_ff, clr_ptr_in;
   bmcs_req_type        item_ff, item_in, req_item;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [LIM_W-1:0]    num_rows_ff, num_rows_in;
   logic [LIM_W-1:0]    num_cols_ff, num_cols_in;
   logic [CNT_W-1:0]    target_ff, target_in;
   bmcs_rsp_type        rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [MAX_COLS-1:0] wb_row_ff, wb_row_in;

   logic                ram_we;
   logic [ROW_W-1:0]    ram_waddr, ram_raddr_a, ram_raddr_b;
   logic [MAX_COLS-1:0] ram_wdata, rdata_a, rdata_b, new_a, new_b;
   bmcs_eval_type       eval_flags;
   logic                accept, slot_free, commit;
   logic [CNT_W-1:0]    cnt_next;

   assign req_item = '{mode: req_ch.mode, row_a: req_ch.row_a, row_b: req_ch.row_b,
                       col_a: req_ch.col_a, col_b: req_ch.col_b,
                       load_bit: req_ch.load_bit};

   bmcs_ram #(.WIDTH(MAX_COLS), .DEPTH(MAX_ROWS)) u_ram (
      .clock   (clock),
      .we      (ram_we),
      .waddr   (ram_waddr),
      .wdata   (ram_wdata),
      .raddr_a (ram_raddr_a),
      .raddr_b (ram_raddr_b),
      .rdata_a (rdata_a),
      .rdata_b (rdata_b)
   );

   bmcs_eval #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_eval (
      .item       (item_ff),
      .num_rows   (num_rows_ff),
      .num_cols   (num_cols_ff),
      .swap_cnt   (cnt_ff),
      .target     (target_ff),
      .row_a_word (rdata_a),
      .row_b_word (rdata_b),
      .flags      (eval_flags),
      .new_a      (new_a),
      .new_b      (new_b)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign slot_free    = !rsp_valid_ff || rsp_ch.ready;
   assign commit       = (state_ff == ST_EXEC) && slot_free;
   assign cnt_next     = cnt_ff + CNT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ptr_ff   <= '0;
         cnt_ff       <= '0;
         num_rows_ff  <= LIM_W'(64);
         num_cols_ff  <= LIM_W'(64);
         target_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ptr_ff   <= clr_ptr_in;
         cnt_ff       <= cnt_in;
         num_rows_ff  <= num_rows_in;
         num_cols_ff  <= num_cols_in;
         target_ff    <= target_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      rsp_ff    <= rsp_in;
      wb_row_ff <= wb_row_in;
   end

   // register writes
   always_comb begin
      num_rows_in = num_rows_ff;
      num_cols_in = num_cols_ff;
      target_in   = target_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_NUM_ROWS: num_rows_in = csr_ch.data[LIM_W-1:0];
            CSR_NUM_COLS: num_cols_in = csr_ch.data[LIM_W-1:0];
            CSR_TARGET:   target_in   = csr_ch.data[CNT_W-1:0];
            default:      target_in   = target_ff;
         endcase
      end
   end

   assign csr_ch.ready = 1'b1;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_ptr_in   = clr_ptr_ff;
      item_in      = item_ff;
      cnt_in       = cnt_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      wb_row_in    = wb_row_ff;
      ram_we       = 1'b0;
      ram_waddr    = ROW_W'(item_ff.row_a);
      ram_wdata    = new_a;
      ram_raddr_a  = ROW_W'(item_ff.row_a);
      ram_raddr_b  = ROW_W'(item_ff.row_b);
      case (state_ff)
         ST_CLEAR: begin
            ram_we     = 1'b1;
            ram_waddr  = clr_ptr_ff;
            ram_wdata  = '0;
            clr_ptr_in = clr_ptr_ff + ROW_W'(1);
            if (clr_ptr_ff == ROW_W'(MAX_ROWS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            ram_raddr_a = ROW_W'(req_item.row_a);
            ram_raddr_b = ROW_W'(req_item.row_b);
            if (accept) begin
               item_in  = req_item;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (slot_free) begin
               ram_we       = eval_flags.wr_a;
               rsp_valid_in = 1'b1;
               rsp_in.read_bit    = eval_flags.read_bit;
               rsp_in.swapped     = eval_flags.hit;
               rsp_in.index_error = eval_flags.index_error;
               rsp_in.swaps_done  = eval_flags.hit ? cnt_next : cnt_ff;
               rsp_in.done_res    = (eval_flags.hit ? cnt_next : cnt_ff) >= target_ff;
               if (eval_flags.hit) begin
                  cnt_in    = cnt_next;
                  wb_row_in = new_b;
                  state_in  = ST_WRB;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_WRB: begin
            ram_we    = 1'b1;
            ram_waddr = ROW_W'(item_ff.row_b);
            ram_wdata = wb_row_ff;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.read_bit    = rsp_ff.read_bit;
   assign rsp_ch.swapped     = rsp_ff.swapped;
   assign rsp_ch.swaps_done  = rsp_ff.swaps_done;
   assign rsp_ch.done_res    = rsp_ff.done_res;
   assign rsp_ch.index_error = rsp_ff.index_error;

`ifndef SYNTHESIS
   a_cnt_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_EXEC || !commit || !eval_flags.hit) |=> $stable(cnt_ff))
      else $error("swap counter moved without a swap");

   a_wrb_after_exec: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRB) |-> $past(state_ff == ST_EXEC))
      else $error("second row write-back without evaluate step");

   a_rsp_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.swapped && (rsp_ff.index_error || rsp_ff.read_bit)))
      else $error("swap reported together with error or read");
`endif
endmodule
`default_nettype wire
